/* hdl/usc_pkg.sv */
// Package for the unsorted scan table: sizes, request and status codes,
// beat structs and the token and control structs shared by the cell chain.
// No dependencies.
package usc_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyBits  = 64;
  localparam int unsigned DataBits = 32;
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned CntW     = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    REQ_FIND     = 3'd0,
    REQ_INSERT   = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_READ     = 3'd3,
    REQ_CUR_RST  = 3'd4,
    REQ_CUR_NEXT = 3'd5,
    REQ_CUR_SET  = 3'd6,
    REQ_NOP      = 3'd7
  } req_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUP_KEY   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_EMPTY_END = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    SEL_FIRST   = 2'd0,
    SEL_CURRENT = 2'd1,
    SEL_LAST    = 2'd2
  } sel_e;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_LAUNCH,
    FSM_SCAN,
    FSM_COMPACT,
    FSM_FINISH
  } fsm_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] key;
    logic [31:0] value;
    logic [1:0]  which_entry;
    logic [5:0]  position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [63:0] key_out;
    logic [31:0] value_out;
    logic [6:0]  probes;
    logic        ended;
    logic [6:0]  cursor_out;
    logic [6:0]  count_out;
  } out_t;

  // Search token that walks the chain, one cell per cycle.
  typedef struct packed {
    logic                valid;
    logic                rd;
    logic [KeyBits-1:0]  key;
    logic [IdxW-1:0]     target;
    logic                found;
    logic [IdxW-1:0]     idx;
    logic [KeyBits-1:0]  key_out;
    logic [DataBits-1:0] val_out;
  } tok_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic                wr_en;
    logic [IdxW-1:0]     wr_idx;
    logic [KeyBits-1:0]  wr_key;
    logic [DataBits-1:0] wr_val;
    logic                shift_en;
    logic [IdxW-1:0]     shift_idx;
    logic [CntW-1:0]     count;
  } cell_ctrl_t;

endpackage

/* hdl/usc_cell.sv */
// One entry of the scan table chain: holds a key and a data word, matches the
// passing token and hands it to the next cell. Depends on usc_pkg.
module usc_cell (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [usc_pkg::IdxW-1:0]       idx_i,
  input  usc_pkg::cell_ctrl_t            ctrl_i,
  input  usc_pkg::tok_t                  tok_i,
  output usc_pkg::tok_t                  tok_o,
  input  logic [usc_pkg::KeyBits-1:0]    nbr_key_i,
  input  logic [usc_pkg::DataBits-1:0]   nbr_val_i,
  output logic [usc_pkg::KeyBits-1:0]    key_o,
  output logic [usc_pkg::DataBits-1:0]   val_o
);
  import usc_pkg::*;

  logic [KeyBits-1:0]  key_q, key_d;
  logic [DataBits-1:0] val_q, val_d;
  tok_t                tok_q, tok_d;
  logic                tok_valid_q;
  logic                in_range;

  assign in_range = ({1'b0, idx_i} < ctrl_i.count);

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.found) begin
      if (tok_i.rd) begin
        if (tok_i.target == idx_i) begin
          tok_d.found   = 1'b1;
          tok_d.idx     = idx_i;
          tok_d.key_out = key_q;
          tok_d.val_out = val_q;
        end
      end else if (in_range && (tok_i.key == key_q)) begin
        tok_d.found   = 1'b1;
        tok_d.idx     = idx_i;
        tok_d.key_out = key_q;
        tok_d.val_out = val_q;
      end
    end
  end

  always_comb begin
    key_d = key_q;
    val_d = val_q;
    // Compaction pulls the right neighbor down over this entry.
    if (ctrl_i.shift_en && (idx_i >= ctrl_i.shift_idx)) begin
      key_d = nbr_key_i;
      val_d = nbr_val_i;
    end else if (ctrl_i.wr_en && (ctrl_i.wr_idx == idx_i)) begin
      key_d = ctrl_i.wr_key;
      val_d = ctrl_i.wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    tok_q <= tok_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_valid_q <= 1'b0;
    end else begin
      tok_valid_q <= tok_i.valid;
    end
  end

  always_comb begin
    tok_o       = tok_q;
    tok_o.valid = tok_valid_q;
  end

  assign key_o = key_q;
  assign val_o = val_q;

endmodule

/* hdl/unsorted_scan_table.sv */
// Unsorted key/value table: a chain of Capacity entry cells and a sequencer.
// Find, insert (not full), delete and read send a token through the chain:
// the sequencer steps LAUNCH, SCAN (until the token leaves the last cell),
// COMPACT for a delete that hits, then FINISH. Full inserts, cursor operations
// and no-ops go from accept straight to FINISH. One beat at a time.
// Reset (async, active low) clears count, cursor, probe tally and valids.
module unsorted_scan_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  usc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output usc_pkg::out_t out_data_o
);
  import usc_pkg::*;

  fsm_e            state_q, state_d;
  in_t             req_q;
  logic            rd_ok_q, rd_ok_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  tok_t            res_q;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cursor_q, cursor_d;
  logic [CntW-1:0] probes_q, probes_d;
  logic            out_valid_q;
  out_t            out_q, out_d;

  logic            accept;
  logic            needs_tok;
  logic            commit;
  logic            is_full;
  tok_t            launch_tok;
  cell_ctrl_t      ctrl;
  tok_t            tok_chain [Capacity+1];
  logic [KeyBits-1:0]  cell_key [Capacity];
  logic [DataBits-1:0] cell_val [Capacity];
  logic [CntW-1:0] found_probes;

  function automatic req_e req_type_cast(logic [2:0] r);
    return req_e'(r);
  endfunction

  assign accept  = in_valid_i && (state_q == FSM_IDLE);
  assign is_full = (count_q == CntW'(Capacity));
  assign commit  = (state_q == FSM_FINISH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    needs_tok = 1'b0;
    case (req_type_cast(in_data_i.req_type))
      REQ_FIND, REQ_DELETE, REQ_READ: needs_tok = 1'b1;
      REQ_INSERT:                     needs_tok = !is_full;
      default:                        needs_tok = 1'b0;
    endcase
  end

  // Read target and validity, settled at accept.
  always_comb begin
    rd_ok_d  = 1'b0;
    rd_idx_d = '0;
    if (count_q != '0) begin
      case (sel_e'(in_data_i.which_entry))
        SEL_FIRST: begin
          rd_ok_d  = 1'b1;
          rd_idx_d = '0;
        end
        SEL_CURRENT: begin
          rd_ok_d  = (cursor_q < count_q);
          rd_idx_d = cursor_q[IdxW-1:0];
        end
        SEL_LAST: begin
          rd_ok_d  = 1'b1;
          rd_idx_d = IdxW'(count_q - CntW'(1));
        end
        default: rd_ok_d = 1'b0;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE:    if (accept) state_d = needs_tok ? FSM_LAUNCH : FSM_FINISH;
      FSM_LAUNCH:  state_d = FSM_SCAN;
      FSM_SCAN: begin
        if (tok_chain[Capacity].valid) begin
          state_d = ((req_q.req_type == REQ_DELETE) && tok_chain[Capacity].found)
                    ? FSM_COMPACT : FSM_FINISH;
        end
      end
      FSM_COMPACT: state_d = FSM_FINISH;
      FSM_FINISH:  if (commit) state_d = FSM_IDLE;
      default:     state_d = FSM_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != FSM_IDLE);

    launch_tok         = '0;
    launch_tok.valid   = (state_q == FSM_LAUNCH);
    launch_tok.rd      = (req_q.req_type == REQ_READ);
    launch_tok.key     = req_q.key[KeyBits-1:0];
    launch_tok.target  = rd_idx_q;

    ctrl           = '0;
    ctrl.count     = count_q;
    ctrl.wr_en     = commit && (req_q.req_type == REQ_INSERT) && !is_full && !res_q.found;
    ctrl.wr_idx    = count_q[IdxW-1:0];
    ctrl.wr_key    = req_q.key[KeyBits-1:0];
    ctrl.wr_val    = req_q.value[DataBits-1:0];
    ctrl.shift_en  = (state_q == FSM_COMPACT);
    ctrl.shift_idx = res_q.idx;
  end

  assign found_probes = CntW'({1'b0, res_q.idx} + (IdxW+1)'(1));

  // Result and state update at commit
  always_comb begin
    count_d  = count_q;
    cursor_d = cursor_q;
    probes_d = probes_q;
    out_d    = '0;
    out_d.status = ST_OK;
    case (req_type_cast(req_q.req_type))
      REQ_FIND: begin
        if (res_q.found) begin
          cursor_d        = CntW'(res_q.idx);
          probes_d        = found_probes;
          out_d.hit       = 1'b1;
          out_d.value_out = 32'(res_q.val_out);
        end else begin
          probes_d     = count_q;
          out_d.status = ST_NOT_FOUND;
        end
      end
      REQ_INSERT: begin
        if (is_full) begin
          out_d.status = ST_FULL;
        end else if (res_q.found) begin
          cursor_d     = CntW'(res_q.idx);
          probes_d     = found_probes;
          out_d.status = ST_DUP_KEY;
        end else begin
          probes_d = count_q;
          count_d  = count_q + CntW'(1);
        end
      end
      REQ_DELETE: begin
        if (res_q.found) begin
          cursor_d        = CntW'(res_q.idx);
          probes_d        = found_probes;
          count_d         = count_q - CntW'(1);
          out_d.hit       = 1'b1;
          out_d.value_out = 32'(res_q.val_out);
        end else begin
          probes_d     = count_q;
          out_d.status = ST_NOT_FOUND;
        end
      end
      REQ_READ: begin
        if (rd_ok_q) begin
          out_d.hit       = 1'b1;
          out_d.key_out   = 64'(res_q.key_out);
          out_d.value_out = 32'(res_q.val_out);
        end else begin
          out_d.status = ST_EMPTY_END;
        end
      end
      REQ_CUR_RST:  cursor_d = '0;
      REQ_CUR_NEXT: if (cursor_q < count_q) cursor_d = cursor_q + CntW'(1);
      REQ_CUR_SET: begin
        cursor_d = (CntW'(req_q.position) < count_q) ? CntW'(req_q.position) : '0;
      end
      default: ;
    endcase
    out_d.probes     = 7'(probes_d);
    out_d.ended      = (cursor_d >= count_d);
    out_d.cursor_out = 7'(cursor_d);
    out_d.count_out  = 7'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      count_q     <= '0;
      cursor_q    <= '0;
      probes_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q  <= count_d;
        cursor_q <= cursor_d;
        probes_q <= probes_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= in_data_i;
      rd_ok_q  <= rd_ok_d;
      rd_idx_q <= rd_idx_d;
    end
    if (accept) begin
      res_q <= '0;
    end else if ((state_q == FSM_SCAN) && tok_chain[Capacity].valid) begin
      res_q <= tok_chain[Capacity];
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

  assign tok_chain[0] = launch_tok;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [KeyBits-1:0]  nbr_key;
    logic [DataBits-1:0] nbr_val;
    if (i < Capacity - 1) begin : g_nbr
      assign nbr_key = cell_key[i+1];
      assign nbr_val = cell_val[i+1];
    end else begin : g_end
      assign nbr_key = '0;
      assign nbr_val = '0;
    end
    usc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (IdxW'(i)),
      .ctrl_i    (ctrl),
      .tok_i     (tok_chain[i]),
      .tok_o     (tok_chain[i+1]),
      .nbr_key_i (nbr_key),
      .nbr_val_i (nbr_val),
      .key_o     (cell_key[i]),
      .val_o     (cell_val[i])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("entry count beyond capacity");

  a_cursor_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= count_q)
    else $error("cursor past entry count");

  a_tok_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_chain[Capacity].valid |-> (state_q == FSM_SCAN))
    else $error("token left chain outside scan");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == FSM_FINISH))
    else $error("result beat raised outside finish");

endmodule
